>>> rtl/lqh_pkg.sv
// ----------------------------------------------------------------------------
// lqh_pkg
// shared types and constants of the link quality hysteresis block
// ----------------------------------------------------------------------------
package lqh_pkg;

    localparam int LINKS     = 16;
    localparam int LINK_W    = 4;
    localparam int FUNC_W    = 3;
    localparam int ST_W      = 3;
    localparam int Q_W       = 16;
    localparam int HOLD_W    = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_INIT    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_GOOD    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_MISS    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_REFRESH = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SNAP    = 3'd4;

    // link status codes
    localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd0;
    localparam logic [ST_W-1:0] ST_PENDING = 3'd1;
    localparam logic [ST_W-1:0] ST_LOST    = 3'd2;
    localparam logic [ST_W-1:0] ST_HEARD   = 3'd3;
    localparam logic [ST_W-1:0] ST_SYM     = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HYST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REJECT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUAL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEND  = 3'd5;

    // configuration reset values
    localparam logic [Q_W-1:0]    RST_HYST   = 16'd32768;
    localparam logic [Q_W-1:0]    RST_ACCEPT = 16'd52429;
    localparam logic [Q_W-1:0]    RST_REJECT = 16'd19661;
    localparam logic [HOLD_W-1:0] RST_HOLD   = 32'd6000;
    localparam logic [Q_W-1:0]    RST_SQUAL  = 16'd0;
    localparam logic              RST_SPEND  = 1'b1;

    // q0.16 one
    localparam logic [Q_W:0] Q_ONE = 17'h10000;

    typedef struct packed {
        logic [Q_W-1:0]  q;
        logic            pend;
        logic            lost;
        logic [ST_W-1:0] st;
        logic [ST_W-1:0] prev;
    } entry_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic upd;
    } ctrl_cmd_t;

endpackage

>>> rtl/link_quality_hysteresis.sv
// ----------------------------------------------------------------------------
// link_quality_hysteresis
// per-link quality smoothing with accept/reject hysteresis and link status
// ----------------------------------------------------------------------------
// Each transaction reads one of 16 link entries, runs it through a shared
// 17x16 smoothing multiplier and writes it back in capture, multiply and
// update steps; update stalls while an earlier result waits. No new
// transaction is taken until update is done, but the result register lets
// the next one start while the last result still waits. Entry state lives
// in flip-flops set by reset; no clearing pass is needed. The user writes
// configuration only while the block is idle; the block does not enforce it.
module link_quality_hysteresis #(
    parameter int TIME_BITS = 32,
    localparam int IN_W  = ((7 + 4 * TIME_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((28 + TIME_BITS + 7) / 8) * 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lqh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lqh_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // func, link, now, heard_until, sym_until, expiry_in
    input  logic [IN_W-1:0]               s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // link_out, status, status_changed, sym_changed, quality_out, lost_out,
    // pending_out, expiry_out, expiry_moved
    output logic [OUT_W-1:0]              m_tdata
);
    import lqh_pkg::*;

    ctrl_cmd_t cmd;

    lqh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    lqh_dp #(
        .TIME_BITS (TIME_BITS),
        .IN_W      (IN_W),
        .OUT_W     (OUT_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata)
    );

endmodule

>>> rtl/lqh_ctrl.sv
// ----------------------------------------------------------------------------
// lqh_ctrl
// sequencer for read, multiply and update of one link entry per transaction
// ----------------------------------------------------------------------------
module lqh_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output lqh_pkg::ctrl_cmd_t cmd
);
    import lqh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_vld_reg;
    logic   out_vld_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_vld_reg;

    always_comb
    begin
        cmd.load = s_tvalid && (state_reg == S_IDLE);
        cmd.mul  = (state_reg == S_MUL);
        cmd.upd  = (state_reg == S_UPD) && (!out_vld_reg || m_tready);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (cmd.upd)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (cmd.upd)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

`ifndef ASSERT_OFF
    a_load_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_MUL))
        else $error("accepted transaction did not start the multiply step");

    a_upd_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |=> m_tvalid)
        else $error("update did not present a result");

    a_single_upd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |=> !cmd.upd)
        else $error("two updates for one transaction");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> !$past(cmd.upd) || $past(out_vld_reg) == 1'b0 ||
        $past(m_tready))
        else $error("pending result overwritten");
`endif

endmodule

>>> rtl/lqh_dp.sv
// ----------------------------------------------------------------------------
// lqh_dp
// link entry store, smoothing multiplier, status decision and result register
// ----------------------------------------------------------------------------
module lqh_dp #(
    parameter int TIME_BITS = 32,
    parameter int IN_W      = 136,
    parameter int OUT_W     = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lqh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lqh_pkg::CFG_W-1:0]         cfg_data,
    input  lqh_pkg::ctrl_cmd_t                cmd,
    input  logic [IN_W-1:0]                   s_tdata,
    output logic [OUT_W-1:0]                  m_tdata
);
    import lqh_pkg::*;

    localparam int T = TIME_BITS;

    // input field offsets
    localparam int I_LINK  = FUNC_W;
    localparam int I_NOW   = I_LINK + LINK_W;
    localparam int I_HEARD = I_NOW + T;
    localparam int I_SYM   = I_HEARD + T;
    localparam int I_EXP   = I_SYM + T;

    // configuration
    logic [Q_W-1:0]    hyst_reg;
    logic [Q_W-1:0]    accept_reg;
    logic [Q_W-1:0]    reject_reg;
    logic [HOLD_W-1:0] hold_reg;
    logic [Q_W-1:0]    squal_reg;
    logic              spend_reg;

    // transaction capture
    logic [FUNC_W-1:0] func_reg;
    logic [LINK_W-1:0] link_reg;
    logic [T-1:0]      now_reg;
    logic [T-1:0]      heard_reg;
    logic [T-1:0]      sym_reg;
    logic [T-1:0]      exp_reg;

    // multiply step
    entry_t            ent_reg [LINKS];
    entry_t            entry_reg;
    logic [2*Q_W:0]    prod_reg;
    logic [T-1:0]      heard_sum_reg;
    logic [T-1:0]      now_sum_reg;
    logic [OUT_W-1:0]  out_reg;

    logic [Q_W:0]      inv_s;
    logic [2*Q_W:0]    prod_next;
    logic [63:0]       hold_ext;
    logic [T-1:0]      hold_t;
    logic [T:0]        heard_add;
    logic [T:0]        now_add;

    // update step
    logic              in_range;
    logic [2*Q_W:0]    rise_sum;
    logic [Q_W-1:0]    rise_q;
    logic [Q_W-1:0]    decay_q;
    entry_t            upd_ent;
    logic              do_dec;
    logic              chg;
    logic              symchg;
    logic [T-1:0]      exp_out;
    logic [OUT_W-1:0]  out_next;

    function automatic logic [ST_W-1:0] decide(input logic pend, input logic lost,
                                               input logic sym_ok, input logic heard_ok);
        logic [ST_W-1:0] st;
        if (pend)
            st = ST_PENDING;
        else if (lost)
            st = ST_LOST;
        else if (sym_ok)
            st = ST_SYM;
        else if (heard_ok)
            st = ST_HEARD;
        else
            st = ST_LOST;
        return st;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyst_reg   <= RST_HYST;
            accept_reg <= RST_ACCEPT;
            reject_reg <= RST_REJECT;
            hold_reg   <= RST_HOLD;
            squal_reg  <= RST_SQUAL;
            spend_reg  <= RST_SPEND;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HYST:   hyst_reg   <= cfg_data[Q_W-1:0];
                CFG_ACCEPT: accept_reg <= cfg_data[Q_W-1:0];
                CFG_REJECT: reject_reg <= cfg_data[Q_W-1:0];
                CFG_HOLD:   hold_reg   <= cfg_data[HOLD_W-1:0];
                CFG_SQUAL:  squal_reg  <= cfg_data[Q_W-1:0];
                CFG_SPEND:  spend_reg  <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= s_tdata[FUNC_W-1:0];
            link_reg  <= s_tdata[I_LINK +: LINK_W];
            now_reg   <= s_tdata[I_NOW +: T];
            heard_reg <= s_tdata[I_HEARD +: T];
            sym_reg   <= s_tdata[I_SYM +: T];
            exp_reg   <= s_tdata[I_EXP +: T];
        end
    end

    // multiply step: (1 - s) * q and saturating time sums
    always_comb
    begin
        inv_s     = Q_ONE - {1'b0, hyst_reg};
        prod_next = (2*Q_W+1)'(inv_s) * (2*Q_W+1)'(ent_reg[link_reg].q);
        hold_ext  = {32'b0, hold_reg};
        hold_t    = hold_ext[T-1:0];
        heard_add = {1'b0, heard_reg} + {1'b0, hold_t};
        now_add   = {1'b0, now_reg} + {1'b0, hold_t};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            entry_reg     <= ent_reg[link_reg];
            prod_reg      <= prod_next;
            heard_sum_reg <= heard_add[T] ? {T{1'b1}} : heard_add[T-1:0];
            now_sum_reg   <= now_add[T] ? {T{1'b1}} : now_add[T-1:0];
        end
    end

    // update step
    always_comb
    begin
        in_range = ({1'b0, link_reg} < (LINK_W+1)'(LINKS));
        rise_sum = prod_reg + {1'b0, hyst_reg, {Q_W{1'b0}}};
        rise_q   = rise_sum[2*Q_W] ? {Q_W{1'b1}} : rise_sum[2*Q_W-1:Q_W];
        decay_q  = prod_reg[2*Q_W-1:Q_W];
        upd_ent  = entry_reg;
        do_dec   = 1'b0;
        chg      = 1'b0;
        symchg   = 1'b0;
        exp_out  = exp_reg;
        case (func_reg)
            FN_INIT:
            begin
                upd_ent.q    = squal_reg;
                upd_ent.pend = spend_reg;
                upd_ent.lost = 1'b0;
                upd_ent.st   = ST_UNKNOWN;
                upd_ent.prev = ST_UNKNOWN;
            end
            FN_GOOD:
            begin
                upd_ent.q = rise_q;
                if (rise_q >= accept_reg)
                begin
                    upd_ent.pend = 1'b0;
                    upd_ent.lost = 1'b0;
                    do_dec       = 1'b1;
                end
            end
            FN_MISS:
            begin
                upd_ent.q = decay_q;
                if ((entry_reg.st != ST_PENDING) && (decay_q <= reject_reg) &&
                    !entry_reg.lost)
                begin
                    upd_ent.lost = 1'b1;
                    if (exp_reg > now_sum_reg)
                    begin
                        exp_out = now_sum_reg;
                    end
                end
            end
            FN_REFRESH:
            begin
                do_dec = 1'b1;
            end
            FN_SNAP:
            begin
                upd_ent.prev = entry_reg.st;
            end
            default:
            begin
            end
        endcase
        if (do_dec)
        begin
            upd_ent.st = decide(upd_ent.pend, upd_ent.lost,
                                sym_reg >= now_reg, heard_reg >= now_reg);
            chg    = (upd_ent.st != upd_ent.prev);
            symchg = chg && ((upd_ent.st == ST_SYM) || (upd_ent.prev == ST_SYM));
            if ((func_reg == FN_GOOD) &&
                ((upd_ent.st == ST_HEARD) || (upd_ent.st == ST_SYM)) &&
                (exp_reg < heard_sum_reg))
            begin
                exp_out = heard_sum_reg;
            end
        end
        if (in_range)
        begin
            out_next = OUT_W'({exp_out != exp_reg, exp_out, upd_ent.pend, upd_ent.lost,
                               upd_ent.q, symchg, chg, upd_ent.st, link_reg});
        end
        else
        begin
            out_next = OUT_W'({1'b0, exp_reg, 1'b0, 1'b0, {Q_W{1'b0}}, 1'b0, 1'b0,
                               ST_UNKNOWN, link_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LINKS; i++)
            begin
                ent_reg[i] <= '{q: '0, pend: 1'b1, lost: 1'b0,
                                st: ST_UNKNOWN, prev: ST_UNKNOWN};
            end
        end
        else if (cmd.upd && in_range)
        begin
            ent_reg[link_reg] <= upd_ent;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tdata = out_reg;

endmodule
